/* hdl/htbp_pkg.sv */
`timescale 1ns / 1ps

package htbp_pkg;

  // field widths fixed by the channel format
  localparam int BYTE_BITS   = 8;
  localparam int SYMBOL_W    = 8;
  localparam int CODE_IN_W   = 32;
  localparam int LEN_IN_W    = 6;
  localparam int TOTAL_W     = 32;
  localparam int CODE_CAP    = 32;

  // parameter defaults
  localparam int DEF_MAX_CODE_BITS = 32;
  localparam int DEF_SYMBOL_COUNT  = 256;

  // item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  // lookup stage control, table to packer
  typedef struct packed {
    logic valid;
    logic encode;
    logic flush;
    logic hit;
  } lookup_ctl_t;

  // packer result control, packer to output buffer
  typedef struct packed {
    logic has_result;
    logic is_data;
  } pack_ctl_t;

endpackage

/* hdl/htbp_table.sv */
`timescale 1ns / 1ps

module htbp_table #(
  parameter int LIMIT        = 32,
  parameter int LEN_W        = 6,
  parameter int SYMBOL_COUNT = 256,
  parameter int ADDR_W       = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                acc,
  input  logic [1:0]                          kind,
  input  logic [htbp_pkg::SYMBOL_W-1:0]       symbol,
  input  logic [htbp_pkg::CODE_IN_W-1:0]      code_bits,
  input  logic [htbp_pkg::LEN_IN_W-1:0]       code_length,
  input  logic                                adv,
  output htbp_pkg::lookup_ctl_t               lk_ctl,
  output logic [LIMIT-1:0]                    lk_code,
  output logic [LEN_W-1:0]                    lk_len
);

  logic                        in_range;
  logic [ADDR_W-1:0]           addr;
  logic [LEN_W-1:0]            len_sat;
  logic                        is_load;
  logic                        is_work;
  logic [SYMBOL_COUNT-1:0]     valid_bits;
  logic [LEN_W+LIMIT-1:0]      mem [SYMBOL_COUNT];
  logic [LEN_W+LIMIT-1:0]      rd_data;

  // address decode and length saturation
  always_comb begin
    in_range = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
    addr     = symbol[ADDR_W-1:0];
    is_load  = (kind == htbp_pkg::KIND_LOAD);
    is_work  = (kind == htbp_pkg::KIND_ENCODE) || (kind == htbp_pkg::KIND_FLUSH);
    if (code_length > htbp_pkg::LEN_IN_W'(LIMIT)) begin
      len_sat = LEN_W'(LIMIT);
    end else begin
      len_sat = code_length[LEN_W-1:0];
    end
  end

  // code table: load writes, every transaction reads
  always_ff @(posedge clk) begin
    if (acc && is_load && in_range) begin
      mem[addr] <= {len_sat, code_bits[LIMIT-1:0]};
    end
    if (acc) begin
      rd_data <= mem[addr];
    end
  end

  // valid marks, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (acc && is_load && in_range) begin
      valid_bits[addr] <= 1'b1;
    end
  end

  // lookup stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      lk_ctl <= '0;
    end else if (acc && is_work) begin
      lk_ctl.valid  <= 1'b1;
      lk_ctl.encode <= (kind == htbp_pkg::KIND_ENCODE);
      lk_ctl.flush  <= (kind == htbp_pkg::KIND_FLUSH);
      lk_ctl.hit    <= in_range && valid_bits[addr];
    end else if (adv) begin
      lk_ctl.valid <= 1'b0;
    end
  end

  assign lk_code = rd_data[LIMIT-1:0];
  assign lk_len  = rd_data[LEN_W+LIMIT-1:LIMIT];

endmodule

/* hdl/htbp_packer.sv */
`timescale 1ns / 1ps

module htbp_packer #(
  parameter int LIMIT     = 32,
  parameter int LEN_W     = 6,
  parameter int MAX_BYTES = 4,
  parameter int CNT_W     = 3
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  htbp_pkg::lookup_ctl_t                 lk_ctl,
  input  logic [LIMIT-1:0]                      lk_code,
  input  logic [LEN_W-1:0]                      lk_len,
  input  logic                                  take,
  output htbp_pkg::pack_ctl_t                   pk_ctl,
  output logic [MAX_BYTES*htbp_pkg::BYTE_BITS-1:0] pk_bytes,
  output logic [CNT_W-1:0]                      pk_count,
  output logic [htbp_pkg::TOTAL_W-1:0]          pk_total
);

  localparam int WW   = LIMIT + htbp_pkg::BYTE_BITS;
  localparam int SH_W = $clog2(WW + 1);

  // accumulator
  logic [htbp_pkg::BYTE_BITS-1:0] pend;
  logic [2:0]                     pc;
  logic [htbp_pkg::TOTAL_W-1:0]   counter;

  logic [LEN_W-1:0]               eff_len;
  logic [WW-1:0]                  mask;
  logic [WW-1:0]                  win;
  logic [WW-1:0]                  aligned;
  logic [SH_W-1:0]                tot;
  logic [CNT_W-1:0]               enc_count;
  logic [2:0]                     new_pc;
  logic [htbp_pkg::BYTE_BITS-1:0] pend_enc;
  logic [htbp_pkg::BYTE_BITS-1:0] flush_byte;
  logic [MAX_BYTES*htbp_pkg::BYTE_BITS-1:0] enc_bytes;

  // splice code under pending bits and left-align the window
  always_comb begin
    eff_len   = lk_ctl.hit ? lk_len : '0;
    mask      = ~({WW{1'b1}} << eff_len);
    win       = ({{(WW-htbp_pkg::BYTE_BITS){1'b0}}, pend} << eff_len)
              | ({{htbp_pkg::BYTE_BITS{1'b0}}, lk_code} & mask);
    tot       = SH_W'(pc) + SH_W'(eff_len);
    aligned   = win << (SH_W'(WW) - tot);
    enc_count = CNT_W'(tot >> 3);
    new_pc    = tot[2:0];
    pend_enc  = win[htbp_pkg::BYTE_BITS-1:0] & ~(8'hFF << new_pc);
    flush_byte = 8'(pend << (4'(htbp_pkg::BYTE_BITS) - {1'b0, pc}));
  end

  // byte slices, first code bit at the top
  for (genvar k = 0; k < MAX_BYTES; k++) begin : g_byte
    assign enc_bytes[k*htbp_pkg::BYTE_BITS +: htbp_pkg::BYTE_BITS] =
      aligned[WW-1-k*htbp_pkg::BYTE_BITS -: htbp_pkg::BYTE_BITS];
  end

  // result for the item in the lookup stage
  always_comb begin
    if (lk_ctl.flush) begin
      pk_ctl.has_result = 1'b1;
      pk_ctl.is_data    = (pc != 3'd0);
      pk_bytes          = '0;
      pk_bytes[htbp_pkg::BYTE_BITS-1:0] = (pc != 3'd0) ? flush_byte : '0;
      pk_count          = CNT_W'(1);
      pk_total          = counter;
    end else begin
      pk_ctl.has_result = (enc_count != '0);
      pk_ctl.is_data    = 1'b1;
      pk_bytes          = enc_bytes;
      pk_count          = enc_count;
      pk_total          = '0;
    end
  end

  // accumulator update when the lookup stage moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= '0;
      pc      <= '0;
      counter <= '0;
    end else if (take && lk_ctl.valid) begin
      if (lk_ctl.flush) begin
        pend    <= '0;
        pc      <= '0;
        counter <= '0;
      end else if (lk_ctl.encode) begin
        pend    <= pend_enc;
        pc      <= new_pc;
        counter <= counter + htbp_pkg::TOTAL_W'(eff_len);
      end
    end
  end

endmodule

/* hdl/htbp_outbuf.sv */
`timescale 1ns / 1ps

module htbp_outbuf #(
  parameter int MAX_BYTES = 4,
  parameter int CNT_W     = 3,
  parameter int IDX_W     = 2
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     ld,
  input  htbp_pkg::pack_ctl_t                      pk_ctl,
  input  logic [MAX_BYTES*htbp_pkg::BYTE_BITS-1:0] pk_bytes,
  input  logic [CNT_W-1:0]                         pk_count,
  input  logic [htbp_pkg::TOTAL_W-1:0]             pk_total,
  output logic                                     free,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [htbp_pkg::BYTE_BITS-1:0]           out_byte,
  output logic                                     is_data,
  output logic [htbp_pkg::TOTAL_W-1:0]             bit_total,
  output logic                                     last
);

  logic                           ob_valid;
  logic [htbp_pkg::BYTE_BITS-1:0] bytes_q [MAX_BYTES];
  logic [CNT_W-1:0]               count;
  logic [IDX_W-1:0]               idx;
  logic                           data_q;
  logic [htbp_pkg::TOTAL_W-1:0]   total_q;
  logic                           pop;

  // output side of the buffer
  always_comb begin
    out_valid = ob_valid;
    out_byte  = bytes_q[idx];
    is_data   = data_q;
    bit_total = total_q;
    last      = (CNT_W'(idx) + CNT_W'(1) == count);
    pop       = ob_valid && !out_stall;
    free      = !ob_valid || (pop && last);
  end

  // control: occupancy and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      idx      <= '0;
    end else if (ld) begin
      ob_valid <= 1'b1;
      idx      <= '0;
    end else if (pop) begin
      if (last) begin
        ob_valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (ld) begin
      for (int k = 0; k < MAX_BYTES; k++) begin
        bytes_q[k] <= pk_bytes[k*htbp_pkg::BYTE_BITS +: htbp_pkg::BYTE_BITS];
      end
      count   <= pk_count;
      data_q  <= pk_ctl.is_data;
      total_q <= pk_total;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    ob_valid |-> (CNT_W'(idx) < count))
    else $error("byte index beyond stored count");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ld |-> free)
    else $error("buffer overwritten before drained");

  a_more_bytes: assert property (@(posedge clk) disable iff (rst)
    (pop && !last) |=> (ob_valid && !$stable(idx)))
    else $error("transaction dropped before its last byte");

endmodule

/* hdl/huffman_table_bit_packer.sv */
`timescale 1ns / 1ps

// channel | handshake             | payload
// in      | in_valid / in_stall   | kind, symbol, code_bits, code_length
// out     | out_valid / out_stall | out_byte, is_data, bit_total, last
//
// an encode or flush is read from the table into the lookup stage, then goes to the output
// buffer if it has a result; an encode yields up to four bytes, one per cycle unless stalled,
// and holds the buffer until its last byte goes; loads only write the table.
// the next item is taken while the buffer drains.
// reset clears the valid marks (256 flops, no clearing pass), the accumulator and the count.
// a stalled output holds its byte; input stalls only when the lookup stage cannot move on.

module huffman_table_bit_packer #(
  parameter int MAX_CODE_BITS = htbp_pkg::DEF_MAX_CODE_BITS,
  parameter int SYMBOL_COUNT  = htbp_pkg::DEF_SYMBOL_COUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [htbp_pkg::SYMBOL_W-1:0]       symbol,
  input  logic [htbp_pkg::CODE_IN_W-1:0]      code_bits,
  input  logic [htbp_pkg::LEN_IN_W-1:0]       code_length,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [htbp_pkg::BYTE_BITS-1:0]      out_byte,
  output logic                                is_data,
  output logic [htbp_pkg::TOTAL_W-1:0]        bit_total,
  output logic                                last
);

  localparam int LIMIT     = (MAX_CODE_BITS < htbp_pkg::CODE_CAP) ? MAX_CODE_BITS
                                                                  : htbp_pkg::CODE_CAP;
  localparam int LEN_W     = $clog2(LIMIT + 1);
  localparam int ADDR_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int MAX_BYTES = (LIMIT + 7) / 8;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  htbp_pkg::lookup_ctl_t                 lk_ctl;
  logic [LIMIT-1:0]                      lk_code;
  logic [LEN_W-1:0]                      lk_len;
  htbp_pkg::pack_ctl_t                   pk_ctl;
  logic [MAX_BYTES*htbp_pkg::BYTE_BITS-1:0] pk_bytes;
  logic [CNT_W-1:0]                      pk_count;
  logic [htbp_pkg::TOTAL_W-1:0]          pk_total;
  logic                                  free;
  logic                                  adv;
  logic                                  acc;

  // pipeline flow
  always_comb begin
    adv      = lk_ctl.valid && (!pk_ctl.has_result || free);
    in_stall = lk_ctl.valid && !adv;
    acc      = in_valid && !in_stall;
  end

  htbp_table #(
    .LIMIT        (LIMIT),
    .LEN_W        (LEN_W),
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .ADDR_W       (ADDR_W)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .kind        (kind),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .adv         (adv),
    .lk_ctl      (lk_ctl),
    .lk_code     (lk_code),
    .lk_len      (lk_len)
  );

  htbp_packer #(
    .LIMIT     (LIMIT),
    .LEN_W     (LEN_W),
    .MAX_BYTES (MAX_BYTES),
    .CNT_W     (CNT_W)
  ) u_packer (
    .clk      (clk),
    .rst      (rst),
    .lk_ctl   (lk_ctl),
    .lk_code  (lk_code),
    .lk_len   (lk_len),
    .take     (adv),
    .pk_ctl   (pk_ctl),
    .pk_bytes (pk_bytes),
    .pk_count (pk_count),
    .pk_total (pk_total)
  );

  htbp_outbuf #(
    .MAX_BYTES (MAX_BYTES),
    .CNT_W     (CNT_W),
    .IDX_W     (IDX_W)
  ) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .ld        (adv && pk_ctl.has_result),
    .pk_ctl    (pk_ctl),
    .pk_bytes  (pk_bytes),
    .pk_count  (pk_count),
    .pk_total  (pk_total),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .bit_total (bit_total),
    .last      (last)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (lk_ctl.valid && out_valid))
    else $error("input stalled with nothing blocking");

endmodule
